// ----- rtl/lfsq_pkg.sv -----
// Shared constants and types for the largest free square finder.
package lfsq_pkg;

	localparam int unsigned MAX_ROWS_DEF = 1024;
	localparam int unsigned MAX_COLS_DEF = 1024;

	localparam int unsigned CFG_DATA_W  = 11;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned SIZE_OUT_W  = 11;
	localparam int unsigned POS_OUT_W   = 10;

	localparam logic [CFG_DATA_W-1:0] ROWS_RESET = 11'd10;
	localparam logic [CFG_DATA_W-1:0] COLS_RESET = 11'd10;

	localparam logic [7:0] FREE_CHAR = 8'd46;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ROWS = 2'd0,
		CFG_COLS = 2'd1
	} cfg_index_t;

	// Per-cell flags that travel with a cell from acceptance into the compute stage.
	typedef struct packed {
		logic is_free;
		logic row0;
		logic col0;
		logic last;
	} cell_ctl_t;

endpackage

// ----- rtl/lfsq_line_buf.sv -----
// Line buffer of previous-row square sizes with a registered read port.
module lfsq_line_buf #(
	parameter int unsigned DEPTH = lfsq_pkg::MAX_COLS_DEF,
	parameter int unsigned AW    = 10,
	parameter int unsigned DW    = 11
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);
	import lfsq_pkg::*;

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// A read that meets a write to the same entry takes the new data, which
	// covers single-column maps where the next cell reads what this one writes.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_q;

endmodule

// ----- rtl/lfsq_scan.sv -----
// Compute stage: min-of-three square size per cell and the running best square.
module lfsq_scan #(
	parameter int unsigned AW = 10,
	parameter int unsigned RW = 10,
	parameter int unsigned SW = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  restart,
	input  logic                  load,
	input  lfsq_pkg::cell_ctl_t   ctl,
	input  logic [RW-1:0]         row,
	input  logic [AW-1:0]         col,
	input  logic                  out_full,
	input  logic [SW-1:0]         up_data,
	output logic                  hold,
	output logic                  wr_en,
	output logic [AW-1:0]         wr_addr,
	output logic [SW-1:0]         wr_data,
	output logic                  done,
	output logic [SW-1:0]         res_size,
	output logic [RW-1:0]         res_row,
	output logic [AW-1:0]         res_col
);
	import lfsq_pkg::*;

	logic          valid_s1;
	cell_ctl_t     ctl_s1;
	logic [RW-1:0] row_s1;
	logic [AW-1:0] col_s1;

	logic [SW-1:0] left_q;
	logic [SW-1:0] diag_q;
	logic [SW-1:0] best_size_q;
	logic [RW-1:0] best_row_q;
	logic [AW-1:0] best_col_q;

	logic [SW-1:0] up_v, left_v, diag_v, min_ul, min_all, size;
	logic          fire, better;

	always_comb begin
		up_v    = ctl_s1.row0 ? '0 : up_data;
		left_v  = ctl_s1.col0 ? '0 : left_q;
		diag_v  = (ctl_s1.row0 || ctl_s1.col0) ? '0 : diag_q;
		min_ul  = (up_v < left_v) ? up_v : left_v;
		min_all = (min_ul < diag_v) ? min_ul : diag_v;
		size    = ctl_s1.is_free ? min_all + SW'(1) : '0;
	end

	assign hold   = valid_s1 && ctl_s1.last && out_full;
	assign fire   = valid_s1 && !hold;
	assign better = size > best_size_q;

	assign wr_en   = fire;
	assign wr_addr = col_s1;
	assign wr_data = size;

	// The result sees this cell's contribution to the best square.
	assign done     = fire && ctl_s1.last;
	assign res_size = better ? size : best_size_q;
	assign res_row  = better ? RW'(32'(row_s1) + 32'd1 - 32'(size)) : best_row_q;
	assign res_col  = better ? AW'(32'(col_s1) + 32'd1 - 32'(size)) : best_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (restart) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ctl_s1 <= ctl;
			row_s1 <= row;
			col_s1 <= col;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			left_q <= size;
			diag_q <= up_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_size_q <= '0;
			best_row_q  <= '0;
			best_col_q  <= '0;
		end else if (restart || done) begin
			best_size_q <= '0;
			best_row_q  <= '0;
			best_col_q  <= '0;
		end else if (fire && better) begin
			best_size_q <= res_size;
			best_row_q  <= res_row;
			best_col_q  <= res_col;
		end
	end

endmodule

// ----- rtl/largest_free_square_finder_core.sv -----
// Top level of the largest free square finder: counters, configuration, result register.
//
// Usage: map cells stream in on the input channel (in_valid, in_stall, cell_char),
// rows_in_use rows of cols_in_use cells each, in row-major order. A cell is free
// when its character is '.'. After the last cell of a frame one result beat leaves
// on the output channel (out_valid, out_stall): found, square_size, top_row and
// left_col of the largest free square, the first in row-major order among equals.
// Throughput is one cell per cycle unless the compute stage holds; each cell does one
// read and one write of the line buffer RAM, and the compute stage finishes a cell
// every cycle. out_valid rises once a frame's last cell has passed the compute stage and
// output registers. When the receiver stalls, the result waits in the output register;
// further cells are still accepted until the next frame's last cell reaches the compute
// stage, which then holds and stalls the input until the result is taken.
// Configuration writes (cfg_write, cfg_index, cfg_data) set rows_in_use (index 0)
// or cols_in_use (index 1); a value of 0 acts as 1 and a value above the maximum
// acts as the maximum. A write to either register restarts the frame.
// Reset clears the position, the running best and out_valid; both registers
// return to 10. The line buffer needs no clearing: row 0 ignores what it reads.
module largest_free_square_finder_core #(
	parameter int unsigned MAX_ROWS = lfsq_pkg::MAX_ROWS_DEF,
	parameter int unsigned MAX_COLS = lfsq_pkg::MAX_COLS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [lfsq_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lfsq_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       cell_char,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             found,
	output logic [lfsq_pkg::SIZE_OUT_W-1:0]  square_size,
	output logic [lfsq_pkg::POS_OUT_W-1:0]   top_row,
	output logic [lfsq_pkg::POS_OUT_W-1:0]   left_col
);
	import lfsq_pkg::*;

	localparam int unsigned AW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int unsigned RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int unsigned CDW  = $clog2(MAX_COLS + 1);
	localparam int unsigned RDW  = $clog2(MAX_ROWS + 1);
	localparam int unsigned MINRC = (MAX_ROWS < MAX_COLS) ? MAX_ROWS : MAX_COLS;
	localparam int unsigned SW   = $clog2(MINRC + 1);

	logic [CFG_DATA_W-1:0] rows_q, cols_q;
	logic [RDW-1:0]        rows_eff;
	logic [CDW-1:0]        cols_eff;
	logic [RW-1:0]         row_q;
	logic [AW-1:0]         col_q;
	logic                  restart, accept, col_last, row_last, hold, out_full;
	cell_ctl_t             ctl;

	logic          wr_en, done;
	logic [AW-1:0] wr_addr;
	logic [SW-1:0] wr_data, up_data, res_size;
	logic [RW-1:0] res_row;
	logic [AW-1:0] res_col;

	logic                  out_valid_q;
	logic [SIZE_OUT_W-1:0] size_q;
	logic [POS_OUT_W-1:0]  row_out_q, col_out_q;

	assign restart = cfg_write && ((cfg_index == CFG_ROWS) || (cfg_index == CFG_COLS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
			cols_q <= COLS_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_ROWS: rows_q <= cfg_data;
				CFG_COLS: cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (rows_q == '0) begin
			rows_eff = RDW'(1);
		end else if (32'(rows_q) > MAX_ROWS) begin
			rows_eff = RDW'(MAX_ROWS);
		end else begin
			rows_eff = RDW'(rows_q);
		end
		if (cols_q == '0) begin
			cols_eff = CDW'(1);
		end else if (32'(cols_q) > MAX_COLS) begin
			cols_eff = CDW'(MAX_COLS);
		end else begin
			cols_eff = CDW'(cols_q);
		end
	end

	assign out_full = out_valid_q && out_stall;
	assign in_stall = hold;
	assign accept   = in_valid && !in_stall;

	assign col_last = (CDW'(col_q) + CDW'(1)) == cols_eff;
	assign row_last = (RDW'(row_q) + RDW'(1)) == rows_eff;

	always_comb begin
		ctl.is_free = (cell_char == FREE_CHAR);
		ctl.row0    = (row_q == '0);
		ctl.col0    = (col_q == '0);
		ctl.last    = col_last && row_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (restart) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (!col_last) begin
				col_q <= col_q + AW'(1);
			end else begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + RW'(1);
			end
		end
	end

	lfsq_line_buf #(
		.DEPTH (MAX_COLS),
		.AW    (AW),
		.DW    (SW)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (up_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	lfsq_scan #(
		.AW (AW),
		.RW (RW),
		.SW (SW)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (restart),
		.load     (accept),
		.ctl      (ctl),
		.row      (row_q),
		.col      (col_q),
		.out_full (out_full),
		.up_data  (up_data),
		.hold     (hold),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.done     (done),
		.res_size (res_size),
		.res_row  (res_row),
		.res_col  (res_col)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			size_q    <= SIZE_OUT_W'(res_size);
			row_out_q <= POS_OUT_W'(res_row);
			col_out_q <= POS_OUT_W'(res_col);
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = (size_q != '0);
	assign square_size = size_q;
	assign top_row     = row_out_q;
	assign left_col    = col_out_q;

`ifndef ASSERT_OFF
	a_done_shows: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> out_valid)
		else $error("finished frame did not reach the output register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> !done)
		else $error("result overwritten while the receiver stalls");

	a_square_fits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !$past(restart) |->
			(32'(top_row) + 32'(square_size) <= 32'(rows_eff)) &&
			(32'(left_col) + 32'(square_size) <= 32'(cols_eff)))
		else $error("reported square lies outside the map");

	a_hold_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		hold |=> $stable(row_q) && $stable(col_q))
		else $error("position advanced while the compute stage held");
`endif

endmodule
